// ----- design/fetb_pkg.sv -----
// ----------------------------------------------------------------------------
// fetb_pkg
// Shared widths, register indexes, reset values and types for the
// friction ellipse torque bounds pipeline.
// ----------------------------------------------------------------------------
package fetb_pkg;

    // input and output field widths
    localparam int FZ_W       = 17;
    localparam int FY_W       = 18;
    localparam int LIM_W      = 17;
    localparam int UB_W       = 16;
    localparam int LB_W       = 17;

    // configuration register widths
    localparam int MU_W       = 15;
    localparam int RADIUS_W   = 16;
    localparam int MINLOAD_W  = 17;
    localparam int FLOOR_W    = 16;

    // datapath widths
    localparam int MUFZ_W     = MU_W + FZ_W;
    localparam int MU_FRAC    = 14;
    localparam int FMAX_W     = MUFZ_W - MU_FRAC;
    localparam int FY2_W      = 2 * FY_W - 1;
    localparam int DISC_W     = 2 * FMAX_W;
    localparam int ROOT_W     = DISC_W / 2;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int TRQP_W     = ROOT_W + RADIUS_W;
    localparam int RADIUS_FRAC = 16;
    localparam int TRQ_W      = TRQP_W - RADIUS_FRAC;

    // end-to-end latency: clamp, two multiply stages, discriminant,
    // root stages, torque multiply, output register
    localparam int LATENCY    = 4 + SQRT_STAGES + 2;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_FRICTION_COEFF = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LOAD       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_FLOOR     = 4'd3;

    localparam logic [MU_W-1:0]      RST_FRICTION_COEFF = 15'd16384;
    localparam logic [RADIUS_W-1:0]  RST_WHEEL_RADIUS   = 16'd13107;
    localparam logic [MINLOAD_W-1:0] RST_MIN_LOAD       = 17'd800;
    localparam logic [FLOOR_W-1:0]   RST_DISC_FLOOR     = 16'd256;

    // about one millimeter in Q0.16 meters
    localparam logic [RADIUS_W-1:0]  MIN_RADIUS         = 16'd66;

    // clamped torque limits that ride along with the datapath
    typedef struct packed {
        logic [UB_W-1:0] motor;
        logic [UB_W-1:0] regen;
    } t_side;

endpackage

// ----- design/fetb_sqrt.sv -----
// ----------------------------------------------------------------------------
// fetb_sqrt
// Pipelined integer square root, one result bit per stage, with a
// sideband that travels alongside the valid bit.
// ----------------------------------------------------------------------------
module fetb_sqrt
    import fetb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DISC_W-1:0] i_radicand,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    localparam int REM_W = ROOT_W + 2;

    logic [SQRT_STAGES-1:0] r_valid;
    logic [REM_W-1:0]       r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0]      r_root [SQRT_STAGES];
    logic [DISC_W-1:0]      r_rad  [SQRT_STAGES];
    t_side                  r_side [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        logic              p_valid;
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [DISC_W-1:0] p_rad;
        t_side             p_side;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [DISC_W-1:0] n_rad;

        // stage input: from the ports or the previous stage
        if (g == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_rad   = i_radicand;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[g-1];
            assign p_rem   = r_rem[g-1];
            assign p_root  = r_root[g-1];
            assign p_rad   = r_rad[g-1];
            assign p_side  = r_side[g-1];
        end

        // bring down two radicand bits and try the next root bit
        always_comb begin
            cur    = {p_rem[REM_W-3:0], p_rad[DISC_W-1 -: 2]};
            trial  = {p_root, 2'b01};
            ge     = (cur >= trial);
            n_rem  = ge ? (cur - trial) : cur;
            n_root = {p_root[ROOT_W-2:0], ge};
            n_rad  = {p_rad[DISC_W-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= p_valid;
            end
            r_rem[g]  <= n_rem;
            r_root[g] <= n_root;
            r_rad[g]  <= n_rad;
            r_side[g] <= p_side;
        end
    end

    assign o_valid = r_valid[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];
    assign o_side  = r_side[SQRT_STAGES-1];

endmodule

// ----- design/friction_ellipse_torque_bounds.sv -----
// Path to o_valid: clamp, multiplies, discriminant, root stages, torque, output.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the square root, one result bit per stage (18 stages).
// Synchronous active-low reset clears the valid bits and loads register
// defaults; results are shown for one cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
// friction_ellipse_torque_bounds
// Per-wheel drive and braking torque bounds from the friction ellipse:
// fmax = mu*Fz, Fx = sqrt(max(fmax^2 - Fy^2, floor)), torque = Fx*r.
// ----------------------------------------------------------------------------
module friction_ellipse_torque_bounds
    import fetb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  start,
    output logic                  busy,
    input  logic [FZ_W-1:0]       i_vertical_load,
    input  logic signed [FY_W-1:0] i_lateral_force,
    input  logic signed [LIM_W-1:0] i_motor_limit,
    input  logic signed [LIM_W-1:0] i_regen_limit,
    // result channel
    output logic                  o_valid,
    output logic [UB_W-1:0]       o_upper_bound,
    output logic signed [LB_W-1:0] o_lower_bound,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [MU_W-1:0]      r_mu;
    logic [RADIUS_W-1:0]  r_radius;
    logic [MINLOAD_W-1:0] r_min_load;
    logic [FLOOR_W-1:0]   r_floor;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu       <= RST_FRICTION_COEFF;
            r_radius   <= RST_WHEEL_RADIUS;
            r_min_load <= RST_MIN_LOAD;
            r_floor    <= RST_DISC_FLOOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FRICTION_COEFF: r_mu       <= i_cfg_data[MU_W-1:0];
                REG_WHEEL_RADIUS:   r_radius   <= i_cfg_data[RADIUS_W-1:0];
                REG_MIN_LOAD:       r_min_load <= i_cfg_data[MINLOAD_W-1:0];
                REG_DISC_FLOOR:     r_floor    <= i_cfg_data[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: clamp load and limits, take lateral force magnitude
    logic             r_s1_valid;
    logic [FZ_W-1:0]  r_s1_fz;
    logic [FY_W-1:0]  r_s1_fy_mag;
    t_side            r_s1_side;
    logic [FZ_W-1:0]  n_s1_fz;
    logic [FY_W-1:0]  n_s1_fy_mag;
    t_side            n_s1_side;

    always_comb begin
        n_s1_fz     = (i_vertical_load < r_min_load) ? r_min_load : i_vertical_load;
        n_s1_fy_mag = i_lateral_force[FY_W-1] ? (~i_lateral_force + 1'b1)
                                              : i_lateral_force;
        n_s1_side.motor = i_motor_limit[LIM_W-1] ? '0 : i_motor_limit[UB_W-1:0];
        n_s1_side.regen = i_regen_limit[LIM_W-1] ? '0 : i_regen_limit[UB_W-1:0];
    end

    // stage 2: fmax = mu*Fz >> 14, Fy^2
    logic              r_s2_valid;
    logic [FMAX_W-1:0] r_s2_fmax;
    logic [FY2_W-1:0]  r_s2_fy2;
    t_side             r_s2_side;
    logic [MUFZ_W-1:0] mu_fz;
    logic [2*FY_W-1:0] fy_sq;

    assign mu_fz = {{FZ_W{1'b0}}, r_mu} * {{MU_W{1'b0}}, r_s1_fz};
    assign fy_sq = {{FY_W{1'b0}}, r_s1_fy_mag} * {{FY_W{1'b0}}, r_s1_fy_mag};

    // stage 3: fmax^2
    logic              r_s3_valid;
    logic [DISC_W-1:0] r_s3_fmax2;
    logic [FY2_W-1:0]  r_s3_fy2;
    t_side             r_s3_side;
    logic [DISC_W-1:0] fmax_sq;

    assign fmax_sq = {{FMAX_W{1'b0}}, r_s2_fmax} * {{FMAX_W{1'b0}}, r_s2_fmax};

    // stage 4: discriminant with floor
    logic                     r_s4_valid;
    logic [DISC_W-1:0]        r_s4_disc;
    t_side                    r_s4_side;
    logic signed [DISC_W:0]   disc_raw;
    logic signed [DISC_W:0]   floor_ext;
    logic [DISC_W-1:0]        n_s4_disc;

    always_comb begin
        disc_raw  = $signed({1'b0, r_s3_fmax2})
                  - $signed({{(DISC_W + 1 - FY2_W){1'b0}}, r_s3_fy2});
        floor_ext = $signed({{(DISC_W + 1 - FLOOR_W){1'b0}}, r_floor});
        n_s4_disc = (disc_raw < floor_ext) ? DISC_W'(r_floor)
                                           : disc_raw[DISC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
        r_s1_fz     <= n_s1_fz;
        r_s1_fy_mag <= n_s1_fy_mag;
        r_s1_side   <= n_s1_side;
        r_s2_fmax   <= mu_fz[MUFZ_W-1:MU_FRAC];
        r_s2_fy2    <= fy_sq[FY2_W-1:0];
        r_s2_side   <= r_s1_side;
        r_s3_fmax2  <= fmax_sq;
        r_s3_fy2    <= r_s2_fy2;
        r_s3_side   <= r_s2_side;
        r_s4_disc   <= n_s4_disc;
        r_s4_side   <= r_s3_side;
    end

    // square root pipeline
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    fetb_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s4_valid),
        .i_radicand (r_s4_disc),
        .i_side     (r_s4_side),
        .o_valid    (sq_valid),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // torque stage: Fx * r >> 16 with the radius clamped
    logic              r_t_valid;
    logic [TRQ_W-1:0]  r_t_trq;
    t_side             r_t_side;
    logic [RADIUS_W-1:0] radius_c;
    logic [TRQP_W-1:0] trq_prod;

    assign radius_c = (r_radius < MIN_RADIUS) ? MIN_RADIUS : r_radius;
    assign trq_prod = {{RADIUS_W{1'b0}}, sq_root} * {{ROOT_W{1'b0}}, radius_c};

    // output stage: intersect with the limits
    logic              r_o_valid;
    logic [UB_W-1:0]   r_o_ub;
    logic [LB_W-1:0]   r_o_lb;
    logic [UB_W-1:0]   n_ub;
    logic [UB_W-1:0]   lb_mag;

    always_comb begin
        n_ub   = (r_t_trq < TRQ_W'(r_t_side.motor)) ? r_t_trq[UB_W-1:0]
                                                    : r_t_side.motor;
        lb_mag = (r_t_trq < TRQ_W'(r_t_side.regen)) ? r_t_trq[UB_W-1:0]
                                                    : r_t_side.regen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_t_valid <= sq_valid;
            r_o_valid <= r_t_valid;
        end
        r_t_trq  <= trq_prod[TRQP_W-1:RADIUS_FRAC];
        r_t_side <= sq_side;
        r_o_ub   <= n_ub;
        r_o_lb   <= LB_W'(0) - {1'b0, lb_mag};
    end

    assign o_valid       = r_o_valid;
    assign o_upper_bound = r_o_ub;
    assign o_lower_bound = r_o_lb;

    // every accepted transaction yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result missing after accepted transaction");

    // no result without a transaction the fixed latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a matching transaction");

    // the braking bound is never positive
    a_lower_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lower_bound[LB_W-1] || o_lower_bound == '0))
        else $error("lower bound is positive");

endmodule
